### hdl/ppp_pkg.sv
package ppp_pkg;

  localparam int unsigned MAX_COLS    = 128;
  localparam int unsigned MAX_ROWS    = 128;
  localparam int unsigned TABLE_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 36;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BEAM_COLS    = 3'd0,
    REG_BEAM_ROWS    = 3'd1,
    REG_MAP_ONLY     = 3'd2,
    REG_START_TIME   = 3'd3,
    REG_FILE_SECONDS = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]  beam_cols;
    logic [7:0]  beam_rows;
    logic        map_only;
    logic [35:0] start_time;
    logic [25:0] file_seconds;
  } cfg_t;

  localparam logic [7:0]  BEAM_COLS_RST    = 8'd80;
  localparam logic [7:0]  BEAM_ROWS_RST    = 8'd125;
  localparam logic        MAP_ONLY_RST     = 1'b0;
  localparam logic [35:0] START_TIME_RST   = 36'd0;
  localparam logic [25:0] FILE_SECONDS_RST = 26'd0;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_MAP  = 2'd1,
    KIND_HDR  = 2'd2,
    KIND_DATA = 2'd3
  } item_kind_e;

  // res_id carries the map entry for a map load and the base time in us for a header
  typedef struct packed {
    item_kind_e         kind;
    logic [IDX_W-1:0]   idx;
    logic [31:0]        res_id;
    logic [1:0]         flag;
    logic               hdr_keep;
    logic [35:0]        ts;
    logic [8:0]         fine;
    logic signed [32:0] phase;
    logic [6:0]         x;
    logic [6:0]         y;
  } fe_item_t;

  localparam logic [7:0]         HDR_MARK      = 8'hFF;
  // ts / 2000 = (ts >> 4) / 125, the latter by reciprocal and one correction
  localparam logic [31:0]        DIV_RECIP     = 32'd2199023255;
  localparam int unsigned        DIV_SHIFT     = 38;
  localparam int unsigned        Q_W           = 64 - DIV_SHIFT;
  localparam logic [32:0]        DIV_LO        = 33'd125;
  localparam logic [27:0]        WRAP_ROUND    = 28'd3;
  localparam int unsigned        WRAP_SHIFT    = 20;
  localparam logic signed [15:0] WRAP_LO       = 16'sd125;
  localparam int unsigned        WRAP_POS      = 24;
  localparam logic [31:0]        US_PER_HALFMS = 32'd500;
  localparam logic signed [15:0] PHASE_SCALE   = 16'sd29335;

  localparam int unsigned FE_STAGES = 6;
  localparam int unsigned Q_DEPTH   = 8;
  localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam int unsigned    RAM_W     = 34;
  localparam logic [RAM_W-1:0] CLR_ENTRY = {2'd1, 32'hFFFF_FFFF};

endpackage

### hdl/ppp_pkt_if.sv
interface ppp_pkt_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] word;
  logic [6:0]  map_x;
  logic [6:0]  map_y;
  logic [31:0] map_res_id;
  logic [7:0]  map_flag;

  modport source (
    output valid, command, word, map_x, map_y, map_res_id, map_flag,
    input  ready
  );
  modport sink (
    input  valid, command, word, map_x, map_y, map_res_id, map_flag,
    output ready
  );
endinterface

### hdl/ppp_phot_if.sv
interface ppp_phot_if;
  logic               valid;
  logic               ready;
  logic [31:0]        res_id;
  logic [31:0]        time_us;
  logic signed [32:0] phase_deg_q24;
  logic [6:0]         pixel_x;
  logic [6:0]         pixel_y;

  modport source (
    output valid, res_id, time_us, phase_deg_q24, pixel_x, pixel_y,
    input  ready
  );
  modport sink (
    input  valid, res_id, time_us, phase_deg_q24, pixel_x, pixel_y,
    output ready
  );
endinterface

### hdl/ppp_cfg_if.sv
interface ppp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [35:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/ppp_ram.sv
module ppp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ppp_front.sv
module ppp_front import ppp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  ppp_pkt_if.sink            pkt_i,
  input  cfg_t               cfg_i,
  input  logic [Q_CNT_W-1:0] q_count_i,
  input  logic               clr_busy_i,
  output logic               push_o,
  output fe_item_t           item_o
);

  fe_item_t               st_q [FE_STAGES];
  fe_item_t               st_d [FE_STAGES];
  logic [FE_STAGES-1:0]   st_vld_q;
  logic [Q_CNT_W:0]       used;
  logic                   accept;

  logic [9:0]             x10;
  logic [9:0]             y10;
  logic                   pix_ok;
  logic                   map_ok;
  logic signed [17:0]     raw_phase;
  logic signed [33:0]     phase_full;
  logic [31:0]            div_in;
  logic [63:0]            div_prod;
  logic [Q_W-1:0]         q0_q;
  logic [Q_W-1:0]         quot_d;
  logic [Q_W-1:0]         quot_q;
  logic [32:0]            rem;
  logic signed [27:0]     diff;
  logic [27:0]            diff_mag;
  logic [7:0]             wr_mag;
  logic signed [7:0]      wraps_d;
  logic signed [7:0]      wraps_q;
  logic signed [15:0]     wrap_lo;
  logic [35:0]            adj;

  assign used = (Q_CNT_W+1)'($countones(st_vld_q)) + (Q_CNT_W+1)'(q_count_i);
  assign pkt_i.ready = !clr_busy_i && (used < (Q_CNT_W+1)'(Q_DEPTH));
  assign accept = pkt_i.valid && pkt_i.ready;

  // classify and decode the incoming beat
  always_comb begin
    x10        = pkt_i.word[63:54];
    y10        = pkt_i.word[53:44];
    pix_ok     = (x10 < 10'(cfg_i.beam_cols)) && (y10 < 10'(cfg_i.beam_rows)) &&
                 (32'(x10) < MAX_COLS) && (32'(y10) < MAX_ROWS);
    map_ok     = (32'(pkt_i.map_x) < MAX_COLS) && (32'(pkt_i.map_y) < MAX_ROWS);
    raw_phase  = pkt_i.word[34:17];
    phase_full = 34'(raw_phase) * 34'(PHASE_SCALE);
    div_in     = pkt_i.word[35:4];
    div_prod   = 64'(div_in) * 64'(DIV_RECIP);

    st_d[0]          = '0;
    st_d[0].ts       = pkt_i.word[35:0];
    st_d[0].fine     = pkt_i.word[43:35];
    st_d[0].phase    = phase_full[32:0];
    st_d[0].x        = x10[6:0];
    st_d[0].y        = y10[6:0];
    st_d[0].res_id   = pkt_i.map_res_id;
    st_d[0].flag     = (pkt_i.map_flag > 8'd1) ? 2'd2 : pkt_i.map_flag[1:0];
    priority if (!pkt_i.command) begin
      st_d[0].kind = map_ok ? KIND_MAP : KIND_NONE;
      st_d[0].idx  = IDX_W'(32'(pkt_i.map_x) * MAX_ROWS + 32'(pkt_i.map_y));
    end else if (pkt_i.word[63:56] == HDR_MARK) begin
      st_d[0].kind = KIND_HDR;
    end else begin
      st_d[0].kind = pix_ok ? KIND_DATA : KIND_NONE;
      st_d[0].idx  = IDX_W'(32'(x10) * MAX_ROWS + 32'(y10));
    end

    // header timestamp: divide, wrap count, repair, subtract run start, scale to us
    rem      = 33'(st_q[0].ts[35:4]) - 33'(q0_q) * DIV_LO;
    quot_d   = q0_q + Q_W'(rem >= DIV_LO);

    diff     = $signed(28'(cfg_i.file_seconds)) + $signed(WRAP_ROUND) - $signed(28'(quot_q));
    diff_mag = diff[27] ? 28'(-diff) : 28'(diff);
    wr_mag   = 8'(diff_mag >> WRAP_SHIFT);
    wraps_d  = diff[27] ? -$signed(wr_mag) : $signed(wr_mag);

    wrap_lo  = 16'(wraps_q) * WRAP_LO;
    adj      = {wrap_lo[35-WRAP_POS:0], WRAP_POS'(0)};

    st_d[1] = st_q[0];
    st_d[2] = st_q[1];
    st_d[3] = st_q[2];
    if (st_q[2].kind == KIND_HDR) begin
      st_d[3].ts = st_q[2].ts + adj;
    end
    st_d[4] = st_q[3];
    if (st_q[3].kind == KIND_HDR) begin
      st_d[4].hdr_keep = st_q[3].ts >= cfg_i.start_time;
      st_d[4].ts       = st_q[3].ts - cfg_i.start_time;
    end
    st_d[5] = st_q[4];
    if (st_q[4].kind == KIND_HDR) begin
      st_d[5].res_id = st_q[4].ts[31:0] * US_PER_HALFMS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= '0;
    end else begin
      st_vld_q <= {st_vld_q[FE_STAGES-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    st_q    <= st_d;
    q0_q    <= div_prod[DIV_SHIFT +: Q_W];
    quot_q  <= quot_d;
    wraps_q <= wraps_d;
  end

  assign push_o = st_vld_q[FE_STAGES-1] && (st_q[FE_STAGES-1].kind != KIND_NONE);
  assign item_o = st_q[FE_STAGES-1];

endmodule

### hdl/ppp_fifo.sv
module ppp_fifo import ppp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fe_item_t           item_i,
  input  logic               pop_i,
  output logic               valid_o,
  output fe_item_t           item_o,
  output logic [Q_CNT_W-1:0] count_o
);

  fe_item_t           mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q;
  logic [Q_PTR_W-1:0] wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q;
  logic [Q_PTR_W-1:0] rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q;
  logic [Q_CNT_W-1:0] cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

### hdl/ppp_back.sv
module ppp_back import ppp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_valid_i,
  input  fe_item_t  q_item_i,
  output logic      q_pop_o,
  output logic      clr_busy_o,
  ppp_phot_if.source phot_o
);

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [RAM_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [RAM_W-1:0]   ram_rdata;

  logic               clr_busy_q;
  logic               clr_busy_d;
  logic [IDX_W-1:0]   clr_cnt_q;
  logic [IDX_W-1:0]   clr_cnt_d;
  logic               open_q;
  logic               open_d;
  logic [31:0]        base_us_q;
  logic [31:0]        base_us_d;

  logic               s1_vld_q;
  logic               s1_vld_d;
  logic [31:0]        s1_time_q;
  logic signed [32:0] s1_phase_q;
  logic [6:0]         s1_x_q;
  logic [6:0]         s1_y_q;

  logic               out_vld_q;
  logic               out_vld_d;
  logic [31:0]        out_res_id_q;
  logic [31:0]        out_time_q;
  logic signed [32:0] out_phase_q;
  logic [6:0]         out_x_q;
  logic [6:0]         out_y_q;

  logic               s1_free;
  logic               out_free;
  logic               is_data;
  logic               take;
  logic               keep_photon;

  ppp_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ppp_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (q_item_i.idx),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    out_free    = !out_vld_q || phot_o.ready;
    s1_free     = !s1_vld_q || out_free;
    is_data     = q_item_i.kind == KIND_DATA;
    q_pop_o     = q_valid_i && !clr_busy_q && (!is_data || s1_free);
    take        = q_pop_o && is_data && open_q;
    ram_re      = take;
    keep_photon = !(cfg_i.map_only && (ram_rdata[RAM_W-1 -: 2] != 2'd0));

    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = CLR_ENTRY;
    end else begin
      ram_we    = q_pop_o && (q_item_i.kind == KIND_MAP);
      ram_waddr = q_item_i.idx;
      ram_wdata = {q_item_i.flag, q_item_i.res_id};
    end

    clr_busy_d = clr_busy_q && (clr_cnt_q != IDX_W'(TABLE_DEPTH - 1));
    clr_cnt_d  = clr_busy_q ? clr_cnt_q + 1'b1 : clr_cnt_q;

    open_d    = open_q;
    base_us_d = base_us_q;
    if (q_pop_o && (q_item_i.kind == KIND_HDR)) begin
      open_d = q_item_i.hdr_keep;
      if (q_item_i.hdr_keep) begin
        base_us_d = q_item_i.res_id;
      end
    end

    s1_vld_d  = s1_free ? take : s1_vld_q;
    out_vld_d = out_free ? (s1_vld_q && keep_photon) : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      open_q     <= 1'b0;
      base_us_q  <= '0;
      s1_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
      open_q     <= open_d;
      base_us_q  <= base_us_d;
      s1_vld_q   <= s1_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_time_q  <= base_us_q + 32'(q_item_i.fine);
      s1_phase_q <= q_item_i.phase;
      s1_x_q     <= q_item_i.x;
      s1_y_q     <= q_item_i.y;
    end
    if (out_free && s1_vld_q) begin
      out_res_id_q <= ram_rdata[31:0];
      out_time_q   <= s1_time_q;
      out_phase_q  <= s1_phase_q;
      out_x_q      <= s1_x_q;
      out_y_q      <= s1_y_q;
    end
  end

  assign clr_busy_o           = clr_busy_q;
  assign phot_o.valid         = out_vld_q;
  assign phot_o.res_id        = out_res_id_q;
  assign phot_o.time_us       = out_time_q;
  assign phot_o.phase_deg_q24 = out_phase_q;
  assign phot_o.pixel_x       = out_x_q;
  assign phot_o.pixel_y       = out_y_q;

endmodule

### hdl/photon_packet_parser.sv
// Path: a data beat passes the front stages, the queue, the back-end stage and
// the output register. Throughput: one beat per cycle, set by the 6-stage front
// pipeline and an 8-entry queue that accepts while the photon output is stalled
// until they hold 8 beats. Reset: asynchronous, active low; registers return to
// their reset values, then the 16384-entry beam map is cleared one entry a cycle
// with the input not ready; configuration writes are taken throughout.
module photon_packet_parser import ppp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppp_cfg_if.sink    cfg_i,
  ppp_pkt_if.sink    pkt_i,
  ppp_phot_if.source phot_o
);

  cfg_t               cfg_q;
  cfg_t               cfg_d;
  logic               push;
  fe_item_t           fe_item;
  logic               pop;
  logic               q_valid;
  fe_item_t           q_item;
  logic [Q_CNT_W-1:0] q_count;
  logic               clr_busy;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_BEAM_COLS:    cfg_d.beam_cols    = cfg_i.data[7:0];
        REG_BEAM_ROWS:    cfg_d.beam_rows    = cfg_i.data[7:0];
        REG_MAP_ONLY:     cfg_d.map_only     = cfg_i.data[0];
        REG_START_TIME:   cfg_d.start_time   = cfg_i.data[35:0];
        REG_FILE_SECONDS: cfg_d.file_seconds = cfg_i.data[25:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beam_cols    <= BEAM_COLS_RST;
      cfg_q.beam_rows    <= BEAM_ROWS_RST;
      cfg_q.map_only     <= MAP_ONLY_RST;
      cfg_q.start_time   <= START_TIME_RST;
      cfg_q.file_seconds <= FILE_SECONDS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ppp_front u_ppp_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pkt_i      (pkt_i),
    .cfg_i      (cfg_q),
    .q_count_i  (q_count),
    .clr_busy_i (clr_busy),
    .push_o     (push),
    .item_o     (fe_item)
  );

  ppp_fifo u_ppp_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (fe_item),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item),
    .count_o (q_count)
  );

  ppp_back u_ppp_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (pop),
    .clr_busy_o (clr_busy),
    .phot_o     (phot_o)
  );

endmodule

### hdl/ppp_checker.sv
module ppp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               cfg_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [31:0]        out_res_id_i,
  input logic [31:0]        out_time_us_i,
  input logic signed [32:0] out_phase_i,
  input logic [6:0]         out_x_i,
  input logic [6:0]         out_y_i
);

  // hold a stalled photon
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("photon dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_res_id_i) && $stable(out_time_us_i) &&
      $stable(out_phase_i) && $stable(out_x_i) && $stable(out_y_i))
    else $error("stalled photon changed");

  // map clear runs right after reset: no beat taken, no photon shown
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_i && !out_valid_i)
    else $error("activity during map clear");

  a_cfg_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> cfg_ready_i)
    else $error("config write blocked while input stalled");

endmodule

bind photon_packet_parser ppp_checker u_ppp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (pkt_i.ready),
  .cfg_ready_i   (cfg_i.ready),
  .out_valid_i   (phot_o.valid),
  .out_ready_i   (phot_o.ready),
  .out_res_id_i  (phot_o.res_id),
  .out_time_us_i (phot_o.time_us),
  .out_phase_i   (phot_o.phase_deg_q24),
  .out_x_i       (phot_o.pixel_x),
  .out_y_i       (phot_o.pixel_y)
);
